>>> hdl/rhr_pkg.sv
`timescale 1ns / 1ps
package rhr_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned RADIUS_W = 11;
  localparam int unsigned HEIGHT_W = 24;
  localparam int unsigned DSQ_W = 21;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned ROOT_IN_W = 38;
  localparam int unsigned DIST_W = ROOT_IN_W / 2;
  localparam int unsigned PROD_W = 43;
  localparam int unsigned NUM_W = 44;
  localparam int unsigned QUOT_W = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] RegCenterX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] RegCenterZ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] RegRadius = 3'd2;
  localparam logic [CFG_IDX_W-1:0] RegFloor = 3'd3;
  localparam logic [CFG_IDX_W-1:0] RegCeiling = 3'd4;
  localparam logic [CFG_IDX_W-1:0] RegAddMode = 3'd5;

  typedef struct packed {
    logic [HEIGHT_W-1:0] base;
    logic in_ramp;
    logic neg;
  } div_side_t;

endpackage

>>> hdl/rhr_sqrt.sv
`timescale 1ns / 1ps
module rhr_sqrt #(
  parameter int unsigned IN_W = rhr_pkg::ROOT_IN_W,
  parameter int unsigned SW = rhr_pkg::HEIGHT_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [IN_W-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [IN_W/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);
  import rhr_pkg::*;

  localparam int unsigned N = IN_W / 2;
  localparam int unsigned REM_W = N + 2;

  logic [N-1:0]     v_q;
  logic [N-1:0]     en;
  logic [REM_W-1:0] rem_q [N];
  logic [N-1:0]     root_q [N];
  logic [IN_W-1:0]  rad_q [N];
  logic [SW-1:0]    side_q [N];

  // one root bit per stage, restoring
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [N-1:0]     root_in;
    logic [IN_W-1:0]  rad_in;
    logic [SW-1:0]    side_in;
    logic [REM_W+1:0] r2;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (k == 0) begin : g_src0
      assign v_in = valid_i;
      assign rem_in = '0;
      assign root_in = '0;
      assign rad_in = rad_i;
      assign side_in = side_i;
    end else begin : g_srcn
      assign v_in = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    if (k == N - 1) begin : g_enl
      assign en[k] = !v_q[k] || ready_i;
    end else begin : g_enm
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign r2 = {rem_in, rad_in[IN_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    assign ge = r2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= ge ? REM_W'(r2 - trial) : REM_W'(r2);
        root_q[k] <= {root_in[N-2:0], ge};
        rad_q[k] <= {rad_in[IN_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];
  assign root_o = root_q[N-1];
  assign side_o = side_q[N-1];

endmodule

>>> hdl/rhr_div.sv
`timescale 1ns / 1ps
module rhr_div #(
  parameter int unsigned NW = rhr_pkg::NUM_W,
  parameter int unsigned DW = rhr_pkg::DIST_W,
  parameter int unsigned QW = rhr_pkg::QUOT_W,
  parameter int unsigned SW = $bits(rhr_pkg::div_side_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);
  import rhr_pkg::*;

  logic [QW-1:0] v_q;
  logic [QW-1:0] en;
  logic [NW-1:0] rem_q [QW];
  logic [QW-1:0] q_q [QW];
  logic [SW-1:0] side_q [QW];

  // divisor is config; the user must keep it steady while items are in flight, the block does not enforce it
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned SH = QW - 1 - k;
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] side_in;
    logic [NW-1:0] dsh;
    logic          ge;

    if (k == 0) begin : g_src0
      assign v_in = valid_i;
      assign rem_in = num_i;
      assign q_in = '0;
      assign side_in = side_i;
    end else begin : g_srcn
      assign v_in = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign q_in = q_q[k-1];
      assign side_in = side_q[k-1];
    end

    if (k == QW - 1) begin : g_enl
      assign en[k] = !v_q[k] || ready_i;
    end else begin : g_enm
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign dsh = NW'(den_i) << SH;
    assign ge = rem_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= ge ? rem_in - dsh : rem_in;
        q_q[k] <= {q_in[QW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[QW-1];
  assign quot_o = q_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

>>> hdl/radial_height_ramp.sv
`timescale 1ns / 1ps
// pipeline: 2 front stages, 19 square root stages, 1 multiply stage,
// 24 divide stages and 2 output stages between input transfer and output valid
// throughput: one item per cycle while the output accepts; each stage moves
// on when the next one is empty or moving, so bubbles close up under output backpressure
// reset: rst_ni async active low clears all valid bits and config registers
module radial_height_ramp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [rhr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rhr_pkg::HEIGHT_W-1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // col[9:0], row[19:10], base_height[43:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_height[23:0]
  output logic        m_axis_tuser   // clipped
);
  import rhr_pkg::*;

  localparam logic signed [HEIGHT_W+2:0] HMax = 27'sd8388607;
  localparam logic signed [HEIGHT_W+2:0] HMin = -27'sd8388608;

  logic [COORD_W-1:0]  cx_q, cz_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [HEIGHT_W-1:0] floor_q, ceil_q;
  logic                add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cz_q <= '0;
      radius_q <= '0;
      floor_q <= '0;
      ceil_q <= '0;
      add_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCenterX: cx_q <= cfg_wdata_i[COORD_W-1:0];
        RegCenterZ: cz_q <= cfg_wdata_i[COORD_W-1:0];
        RegRadius:  radius_q <= cfg_wdata_i[RADIUS_W-1:0];
        RegFloor:   floor_q <= cfg_wdata_i;
        RegCeiling: ceil_q <= cfg_wdata_i;
        RegAddMode: add_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic sq_ready, sq_valid, dv_ready, dv_valid;

  // stage 1: offsets from center
  logic signed [COORD_W:0] dx_q, dz_q;
  logic [HEIGHT_W-1:0]     b1_q;

  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en1) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q <= $signed({1'b0, s_axis_tdata[9:0]}) - $signed({1'b0, cx_q});
      dz_q <= $signed({1'b0, s_axis_tdata[19:10]}) - $signed({1'b0, cz_q});
      b1_q <= s_axis_tdata[43:20];
    end
  end

  // stage 2: squared distance
  logic signed [2*COORD_W+1:0] sqx, sqz;
  logic [DSQ_W-1:0]    d2_q;
  logic [HEIGHT_W-1:0] b2_q;

  assign sqx = dx_q * dx_q;
  assign sqz = dz_q * dz_q;
  assign en2 = !v2_q || sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en2) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      d2_q <= DSQ_W'(unsigned'(sqx) + unsigned'(sqz));
      b2_q <= b1_q;
    end
  end

  logic [DIST_W-1:0]   root_dist;
  logic [HEIGHT_W-1:0] b_sq;

  rhr_sqrt #(
    .IN_W(ROOT_IN_W),
    .SW  (HEIGHT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v2_q),
    .ready_o(sq_ready),
    .rad_i  ({1'b0, d2_q, {(2*FRAC_W){1'b0}}}),
    .side_i (b2_q),
    .valid_o(sq_valid),
    .ready_i(en3),
    .root_o (root_dist),
    .side_o (b_sq)
  );

  // stage 3: compare and scale
  logic [DIST_W-1:0]          rad;
  logic signed [HEIGHT_W:0]   diff;
  logic [HEIGHT_W-1:0]        absd;
  logic [PROD_W-1:0]          prod_q;
  div_side_t                  s3_q;

  assign rad = {radius_q, {FRAC_W{1'b0}}};
  assign diff = $signed({ceil_q[HEIGHT_W-1], ceil_q}) - $signed({floor_q[HEIGHT_W-1], floor_q});
  assign absd = diff[HEIGHT_W] ? HEIGHT_W'(-diff) : diff[HEIGHT_W-1:0];
  assign en3 = !v3_q || dv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en3) v3_q <= sq_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      prod_q <= PROD_W'(absd * root_dist);
      s3_q.base <= b_sq;
      s3_q.in_ramp <= root_dist < rad;
      s3_q.neg <= diff[HEIGHT_W];
    end
  end

  logic [QUOT_W-1:0] quot;
  div_side_t         s_dv;

  rhr_div #(
    .NW(NUM_W),
    .DW(DIST_W),
    .QW(QUOT_W),
    .SW($bits(div_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v3_q),
    .ready_o(dv_ready),
    .num_i  (NUM_W'(prod_q)),
    .den_i  (rad),
    .side_i (s3_q),
    .valid_o(dv_valid),
    .ready_i(en4),
    .quot_o (quot),
    .side_o (s_dv)
  );

  // stage 4: ramp height
  logic signed [QUOT_W:0]     qs;
  logic signed [HEIGHT_W+1:0] h_q;
  logic [HEIGHT_W-1:0]        b4_q;

  assign qs = s_dv.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign en4 = !v4_q || en5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en4) v4_q <= dv_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      h_q <= s_dv.in_ramp ? $signed({{2{floor_q[HEIGHT_W-1]}}, floor_q}) + (HEIGHT_W+2)'(qs)
                          : $signed({{2{ceil_q[HEIGHT_W-1]}}, ceil_q});
      b4_q <= s_dv.base;
    end
  end

  // stage 5: add base height in add mode and saturate into the output register
  logic signed [HEIGHT_W+2:0] sum;
  logic [HEIGHT_W-1:0]        out_q;
  logic                       clip_q;

  assign sum = $signed({h_q[HEIGHT_W+1], h_q})
             + (add_q ? $signed({{3{b4_q[HEIGHT_W-1]}}, b4_q}) : '0);
  assign en5 = !v5_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en5) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      priority if (sum > HMax) begin
        out_q <= HMax[HEIGHT_W-1:0];
        clip_q <= 1'b1;
      end else if (sum < HMin) begin
        out_q <= HMin[HEIGHT_W-1:0];
        clip_q <= 1'b1;
      end else begin
        out_q <= sum[HEIGHT_W-1:0];
        clip_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata = out_q;
  assign m_axis_tuser = clip_q;

  a_clip_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (out_q == 24'h7FFFFF || out_q == 24'h800000))
    else $error("clipped result not at a range limit");

  a_no_clip_wo_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !add_q |-> !m_axis_tuser)
    else $error("clip without add mode");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !dv_ready |=> v3_q && $stable(prod_q))
    else $error("multiply stage lost an item under stall");

endmodule
